// ===== hw/rtl/adll_pkg.sv =====
`timescale 1ns / 1ps

package adll_pkg;

  typedef enum logic [2:0] {
    MODE_INS_HEAD  = 3'd0,
    MODE_INS_AFTER = 3'd1,
    MODE_APPEND    = 3'd2,
    MODE_ERASE     = 3'd3,
    MODE_READ      = 3'd4,
    MODE_CLEAR     = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_LINK,
    S_DONE
  } seq_state_t;

  // One result beat as it leaves the sequencer, already in port format.
  typedef struct packed {
    status_t     status;
    logic [5:0]  slot;
    logic [5:0]  prev_slot;
    logic [5:0]  next_slot;
    logic [31:0] data_out;
    logic [5:0]  head_slot;
    logic [5:0]  tail_slot;
    logic [5:0]  count;
    logic [5:0]  free_slot;
  } result_t;

endpackage

// ===== hw/rtl/array_doubly_linked_list_unit.sv =====
// Array-backed doubly linked list over SLOTS slots with a free chain; the index
// SLOTS means nil. Each input beat (insert at head, insert after a slot, append,
// erase, read, clear) returns exactly one result beat carrying status, the slot
// touched with its links and data, and head, tail, count and free head after the
// step. The links live in two single-port-write memories with registered reads,
// and a sequencer does one read-modify-write pass per beat: an insert, append or
// erase goes through idle, check, link and done, a read or a rejected beat skips link,
// and a clear rewrites one slot per cycle in the clear state before done. After
// reset the same walk runs with in_ready low. A finished result sits in an
// output register, so the sequencer moves on while it waits.
`timescale 1ns / 1ps

module array_doubly_linked_list_unit #(
  parameter int SLOTS = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [4:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot,
  output logic [5:0]  out_prev_slot,
  output logic [5:0]  out_next_slot,
  output logic [31:0] out_data_out,
  output logic [5:0]  out_head_slot,
  output logic [5:0]  out_tail_slot,
  output logic [5:0]  out_count,
  output logic [5:0]  out_free_slot
);

  import adll_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int IW = $clog2(SLOTS + 1);
  localparam int PW = IW + 1;
  localparam int NW = IW + DATA_WIDTH;

  logic          p_we, p_re, n_we, n_re;
  logic [AW-1:0] p_waddr, p_raddr, n_waddr, n_raddr;
  logic [PW-1:0] p_wdata, p_rdata;
  logic [NW-1:0] n_wdata, n_rdata;

  logic    res_valid, res_ready;
  result_t res;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;

  adll_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_prev_ram (
    .clk     (clk),
    .we      (p_we),
    .waddr   (p_waddr),
    .wdata   (p_wdata),
    .re      (p_re),
    .raddr   (p_raddr),
    .rdata_r (p_rdata)
  );

  adll_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_next_ram (
    .clk     (clk),
    .we      (n_we),
    .waddr   (n_waddr),
    .wdata   (n_wdata),
    .re      (n_re),
    .raddr   (n_raddr),
    .rdata_r (n_rdata)
  );

  adll_seq #(.SLOTS(SLOTS), .DATA_WIDTH(DATA_WIDTH)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_position (in_position),
    .in_value    (in_value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .p_we        (p_we),
    .p_waddr     (p_waddr),
    .p_wdata     (p_wdata),
    .p_re        (p_re),
    .p_raddr     (p_raddr),
    .p_rdata     (p_rdata),
    .n_we        (n_we),
    .n_waddr     (n_waddr),
    .n_wdata     (n_wdata),
    .n_re        (n_re),
    .n_raddr     (n_raddr),
    .n_rdata     (n_rdata)
  );

  // Take a new result whenever the output register is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_res_r.status;
  assign out_slot      = out_res_r.slot;
  assign out_prev_slot = out_res_r.prev_slot;
  assign out_next_slot = out_res_r.next_slot;
  assign out_data_out  = out_res_r.data_out;
  assign out_head_slot = out_res_r.head_slot;
  assign out_tail_slot = out_res_r.tail_slot;
  assign out_count     = out_res_r.count;
  assign out_free_slot = out_res_r.free_slot;

endmodule

// ===== hw/rtl/adll_ram.sv =====
`timescale 1ns / 1ps

module adll_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/adll_seq.sv =====
`timescale 1ns / 1ps

module adll_seq #(
  parameter int SLOTS = 32,
  parameter int DATA_WIDTH = 32,
  localparam int AW = $clog2(SLOTS),
  localparam int IW = $clog2(SLOTS + 1),
  localparam int PW = IW + 1,
  localparam int NW = IW + DATA_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_mode,
  input  logic [4:0]        in_position,
  input  logic [31:0]       in_value,
  output logic              res_valid,
  input  logic              res_ready,
  output adll_pkg::result_t res,
  // prev store: {in_list, prev}
  output logic              p_we,
  output logic [AW-1:0]     p_waddr,
  output logic [PW-1:0]     p_wdata,
  output logic              p_re,
  output logic [AW-1:0]     p_raddr,
  input  logic [PW-1:0]     p_rdata,
  // next store: {next, data}
  output logic              n_we,
  output logic [AW-1:0]     n_waddr,
  output logic [NW-1:0]     n_wdata,
  output logic              n_re,
  output logic [AW-1:0]     n_raddr,
  input  logic [NW-1:0]     n_rdata
);

  import adll_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam logic [IW-1:0] Nil = IW'(SLOTS);
  localparam logic [AW-1:0] LastAddr = AW'(SLOTS - 1);

  seq_state_t state_r, state_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic          pos_ok_r, pos_ok_nxt;
  logic [DW-1:0] val_r, val_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] fh_r, fh_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] n1_r, n1_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          clr_reply_r, clr_reply_nxt;
  status_t       st_r, st_nxt;
  logic [IW-1:0] rs_slot_r, rs_slot_nxt;
  logic [IW-1:0] rs_prev_r, rs_prev_nxt;
  logic [IW-1:0] rs_next_r, rs_next_nxt;
  logic [DW-1:0] rs_data_r, rs_data_nxt;
  logic          w2p_en_r, w2p_en_nxt;
  logic [AW-1:0] w2p_addr_r, w2p_addr_nxt;
  logic [PW-1:0] w2p_data_r, w2p_data_nxt;
  logic          w2n_en_r, w2n_en_nxt;
  logic [AW-1:0] w2n_addr_r, w2n_addr_nxt;
  logic [NW-1:0] w2n_data_r, w2n_data_nxt;

  logic          memb;
  logic          full;
  logic [IW-1:0] pos_idx;
  logic [IW-1:0] p_prev;
  logic [IW-1:0] n1_next;
  logic [DW-1:0] n1_data;
  logic [IW-1:0] n2_next;
  logic [DW-1:0] n2_data;

  assign pos_idx = IW'(pos_r);
  assign p_prev  = p_rdata[IW-1:0];
  assign n1_next = n1_r[NW-1 -: IW];
  assign n1_data = n1_r[DW-1:0];
  assign n2_next = n_rdata[NW-1 -: IW];
  assign n2_data = n_rdata[DW-1:0];
  assign memb    = pos_ok_r && p_rdata[IW];
  assign full    = (cnt_r >= Nil) || (fh_r >= Nil);

  assign res.status    = st_r;
  assign res.slot      = 6'(rs_slot_r);
  assign res.prev_slot = 6'(rs_prev_r);
  assign res.next_slot = 6'(rs_next_r);
  assign res.data_out  = 32'(rs_data_r);
  assign res.head_slot = 6'(head_r);
  assign res.tail_slot = 6'(tail_r);
  assign res.count     = 6'(cnt_r);
  assign res.free_slot = 6'(fh_r);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    pos_ok_nxt    = pos_ok_r;
    val_nxt       = val_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fh_nxt        = fh_r;
    cnt_nxt       = cnt_r;
    n1_nxt        = n1_r;
    clr_nxt       = clr_r;
    clr_reply_nxt = clr_reply_r;
    st_nxt        = st_r;
    rs_slot_nxt   = rs_slot_r;
    rs_prev_nxt   = rs_prev_r;
    rs_next_nxt   = rs_next_r;
    rs_data_nxt   = rs_data_r;
    w2p_en_nxt    = w2p_en_r;
    w2p_addr_nxt  = w2p_addr_r;
    w2p_data_nxt  = w2p_data_r;
    w2n_en_nxt    = w2n_en_r;
    w2n_addr_nxt  = w2n_addr_r;
    w2n_data_nxt  = w2n_data_r;

    in_ready  = 1'b0;
    res_valid = 1'b0;
    p_we      = 1'b0;
    p_waddr   = '0;
    p_wdata   = '0;
    n_we      = 1'b0;
    n_waddr   = '0;
    n_wdata   = '0;
    p_re      = 1'b0;
    p_raddr   = AW'(in_position);
    n_re      = 1'b0;
    n_raddr   = AW'(in_position);

    case (state_r)
      S_CLEAR: begin
        // Rebuild one slot a cycle: out of the list, free chain to the next slot.
        p_we    = 1'b1;
        p_waddr = clr_r;
        p_wdata = {1'b0, Nil};
        n_we    = 1'b1;
        n_waddr = clr_r;
        n_wdata = {((clr_r == LastAddr) ? Nil : IW'(clr_r) + IW'(1)), DW'(0)};
        head_nxt = Nil;
        tail_nxt = Nil;
        fh_nxt   = '0;
        cnt_nxt  = '0;
        if (clr_r == LastAddr) begin
          clr_nxt       = '0;
          clr_reply_nxt = 1'b0;
          state_nxt     = clr_reply_r ? S_DONE : S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        p_re     = 1'b1;
        n_re     = 1'b1;
        if (in_mode == MODE_INS_HEAD || in_mode == MODE_APPEND) begin
          n_raddr = fh_r[AW-1:0];
        end
        if (in_valid) begin
          mode_nxt    = in_mode;
          pos_nxt     = AW'(in_position);
          pos_ok_nxt  = int'(in_position) < SLOTS;
          val_nxt     = DW'(in_value);
          st_nxt      = ST_OK;
          rs_slot_nxt = Nil;
          rs_prev_nxt = Nil;
          rs_next_nxt = Nil;
          rs_data_nxt = '0;
          w2p_en_nxt  = 1'b0;
          w2n_en_nxt  = 1'b0;
          if (in_mode == MODE_CLEAR) begin
            clr_nxt       = '0;
            clr_reply_nxt = 1'b1;
            state_nxt     = S_CLEAR;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        n1_nxt    = n_rdata;
        state_nxt = S_DONE;
        case (mode_r)
          MODE_INS_HEAD: begin
            if (full) begin
              st_nxt = ST_FULL;
            end else begin
              state_nxt = S_LINK;
            end
          end
          MODE_INS_AFTER: begin
            if (full) begin
              st_nxt = ST_FULL;
            end else if (!memb) begin
              st_nxt = ST_ABSENT;
            end else begin
              // fetch the free slot's chain link
              n_re      = 1'b1;
              n_raddr   = fh_r[AW-1:0];
              state_nxt = S_LINK;
            end
          end
          MODE_APPEND: begin
            if (full) begin
              st_nxt = ST_FULL;
            end else begin
              n_re      = 1'b1;
              n_raddr   = tail_r[AW-1:0];
              state_nxt = S_LINK;
            end
          end
          MODE_ERASE: begin
            if (cnt_r == '0) begin
              st_nxt = ST_EMPTY;
            end else if (!memb) begin
              st_nxt = ST_ABSENT;
            end else begin
              n_re      = 1'b1;
              n_raddr   = p_prev[AW-1:0];
              state_nxt = S_LINK;
            end
          end
          MODE_READ: begin
            if (cnt_r == '0) begin
              st_nxt = ST_EMPTY;
            end else if (!memb) begin
              st_nxt = ST_ABSENT;
            end else begin
              rs_slot_nxt = pos_idx;
              rs_prev_nxt = p_prev;
              rs_next_nxt = n_rdata[NW-1 -: IW];
              rs_data_nxt = n_rdata[DW-1:0];
            end
          end
          default: begin
          end
        endcase
      end

      S_LINK: begin
        // First write pair goes out now; the second is held for the done state.
        state_nxt = S_DONE;
        case (mode_r)
          MODE_INS_HEAD: begin
            p_we    = 1'b1;
            p_waddr = fh_r[AW-1:0];
            p_wdata = {1'b1, Nil};
            n_we    = 1'b1;
            n_waddr = fh_r[AW-1:0];
            n_wdata = {head_r, val_r};
            w2p_en_nxt   = head_r != Nil;
            w2p_addr_nxt = head_r[AW-1:0];
            w2p_data_nxt = {1'b1, fh_r};
            fh_nxt   = n1_next;
            head_nxt = fh_r;
            tail_nxt = (head_r == Nil) ? fh_r : tail_r;
            cnt_nxt  = cnt_r + IW'(1);
            rs_slot_nxt = fh_r;
            rs_prev_nxt = Nil;
            rs_next_nxt = head_r;
            rs_data_nxt = val_r;
          end
          MODE_INS_AFTER: begin
            p_we    = 1'b1;
            p_waddr = fh_r[AW-1:0];
            p_wdata = {1'b1, pos_idx};
            n_we    = 1'b1;
            n_waddr = fh_r[AW-1:0];
            n_wdata = {n1_next, val_r};
            w2n_en_nxt   = 1'b1;
            w2n_addr_nxt = pos_r;
            w2n_data_nxt = {fh_r, n1_data};
            w2p_en_nxt   = n1_next != Nil;
            w2p_addr_nxt = n1_next[AW-1:0];
            w2p_data_nxt = {1'b1, fh_r};
            fh_nxt   = n2_next;
            tail_nxt = (n1_next == Nil) ? fh_r : tail_r;
            cnt_nxt  = cnt_r + IW'(1);
            rs_slot_nxt = fh_r;
            rs_prev_nxt = pos_idx;
            rs_next_nxt = n1_next;
            rs_data_nxt = val_r;
          end
          MODE_APPEND: begin
            p_we    = 1'b1;
            p_waddr = fh_r[AW-1:0];
            p_wdata = {1'b1, tail_r};
            n_we    = 1'b1;
            n_waddr = fh_r[AW-1:0];
            n_wdata = {Nil, val_r};
            w2n_en_nxt   = tail_r != Nil;
            w2n_addr_nxt = tail_r[AW-1:0];
            w2n_data_nxt = {fh_r, n2_data};
            fh_nxt   = n1_next;
            head_nxt = (tail_r == Nil) ? fh_r : head_r;
            tail_nxt = fh_r;
            cnt_nxt  = cnt_r + IW'(1);
            rs_slot_nxt = fh_r;
            rs_prev_nxt = tail_r;
            rs_next_nxt = Nil;
            rs_data_nxt = val_r;
          end
          MODE_ERASE: begin
            // Unhook the slot and push it onto the front of the free chain.
            p_we    = 1'b1;
            p_waddr = pos_r;
            p_wdata = {1'b0, Nil};
            n_we    = 1'b1;
            n_waddr = pos_r;
            n_wdata = {fh_r, n1_data};
            w2n_en_nxt   = p_prev != Nil;
            w2n_addr_nxt = p_prev[AW-1:0];
            w2n_data_nxt = {n1_next, n2_data};
            w2p_en_nxt   = n1_next != Nil;
            w2p_addr_nxt = n1_next[AW-1:0];
            w2p_data_nxt = {1'b1, p_prev};
            head_nxt = (p_prev == Nil) ? n1_next : head_r;
            tail_nxt = (n1_next == Nil) ? p_prev : tail_r;
            fh_nxt   = pos_idx;
            cnt_nxt  = cnt_r - IW'(1);
            rs_slot_nxt = pos_idx;
            rs_prev_nxt = p_prev;
            rs_next_nxt = n1_next;
            rs_data_nxt = n1_data;
          end
          default: begin
          end
        endcase
      end

      S_DONE: begin
        // Hold the second write pair until the beat is taken; rewriting is harmless.
        res_valid = 1'b1;
        p_we      = w2p_en_r;
        p_waddr   = w2p_addr_r;
        p_wdata   = w2p_data_r;
        n_we      = w2n_en_r;
        n_waddr   = w2n_addr_r;
        n_wdata   = w2n_data_r;
        if (res_ready) begin
          w2p_en_nxt = 1'b0;
          w2n_en_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      clr_reply_r <= 1'b0;
      head_r      <= Nil;
      tail_r      <= Nil;
      fh_r        <= '0;
      cnt_r       <= '0;
      w2p_en_r    <= 1'b0;
      w2n_en_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_reply_r <= clr_reply_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fh_r        <= fh_nxt;
      cnt_r       <= cnt_nxt;
      w2p_en_r    <= w2p_en_nxt;
      w2n_en_r    <= w2n_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    pos_r      <= pos_nxt;
    pos_ok_r   <= pos_ok_nxt;
    val_r      <= val_nxt;
    n1_r       <= n1_nxt;
    st_r       <= st_nxt;
    rs_slot_r  <= rs_slot_nxt;
    rs_prev_r  <= rs_prev_nxt;
    rs_next_r  <= rs_next_nxt;
    rs_data_r  <= rs_data_nxt;
    w2p_addr_r <= w2p_addr_nxt;
    w2p_data_r <= w2p_data_nxt;
    w2n_addr_r <= w2n_addr_nxt;
    w2n_data_r <= w2n_data_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Nil)
    else $error("entry count above capacity");

  a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((head_r == Nil) == (tail_r == Nil)))
    else $error("head and tail disagree on an empty list");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((cnt_r == '0) == (head_r == Nil)))
    else $error("count and head disagree on an empty list");

  a_full_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((cnt_r == Nil) == (fh_r == Nil)))
    else $error("free chain and count disagree on a full list");

endmodule
